// ===== src/pip_pkg.sv =====
// Shared types and constants for the point-in-polygon test block.
// No dependencies; imported by every module under src.
`default_nettype none

package pip_pkg;

   localparam int COORD_BITS   = 16;
   localparam int PT_BITS      = COORD_BITS + 2;
   localparam int DET_BITS     = (2 * COORD_BITS + 7 > 64) ? 64 : 2 * COORD_BITS + 7;
   localparam int RAY_MARGIN   = 10;
   localparam int MIN_VERTICES = 3;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   typedef enum logic [1:0] {
      TURN_COLL = 2'd0,
      TURN_POS  = 2'd1,
      TURN_NEG  = 2'd2
   } turn_type;

   typedef struct packed {
      logic [1:0]                   op;
      logic signed [COORD_BITS-1:0] coord_x;
      logic signed [COORD_BITS-1:0] coord_y;
   } req_type;

   typedef struct packed {
      logic inside_res;
      logic decided_on_edge;
      logic too_few_vertices;
   } rsp_type;

   typedef struct packed {
      logic signed [PT_BITS-1:0] x;
      logic signed [PT_BITS-1:0] y;
   } pt_type;

   typedef struct packed {
      turn_type o1;
      turn_type o2;
      turn_type o3;
      turn_type o4;
      turn_type o5;
   } turns_type;

   typedef struct packed {
      logic crossed;
      logic collinear;
      logic on_edge;
   } verdict_type;

endpackage

`default_nettype wire

// ===== src/pip_turn_unit.sv =====
// Shared orientation unit: sign of (c-b) x (b-a) for three points, exact.
// Depends on pip_pkg.
`default_nettype none

module pip_turn_unit (
   input  pip_pkg::pt_type   pt_a,
   input  pip_pkg::pt_type   pt_b,
   input  pip_pkg::pt_type   pt_c,
   output pip_pkg::turn_type turn
);
   import pip_pkg::*;

   localparam int DIF_BITS = PT_BITS + 1;

   logic signed [DIF_BITS-1:0] dy_ab, dx_bc, dx_ab, dy_bc;
   logic signed [DET_BITS-1:0] t1, t2, det;

   assign dy_ab = $signed({pt_b.y[PT_BITS-1], pt_b.y}) - $signed({pt_a.y[PT_BITS-1], pt_a.y});
   assign dx_bc = $signed({pt_c.x[PT_BITS-1], pt_c.x}) - $signed({pt_b.x[PT_BITS-1], pt_b.x});
   assign dx_ab = $signed({pt_b.x[PT_BITS-1], pt_b.x}) - $signed({pt_a.x[PT_BITS-1], pt_a.x});
   assign dy_bc = $signed({pt_c.y[PT_BITS-1], pt_c.y}) - $signed({pt_b.y[PT_BITS-1], pt_b.y});

   assign t1  = DET_BITS'(dy_ab) * DET_BITS'(dx_bc);
   assign t2  = DET_BITS'(dx_ab) * DET_BITS'(dy_bc);
   assign det = t1 - t2;

   always_comb begin
      if (det == '0) begin
         turn = TURN_COLL;
      end else if (det[DET_BITS-1]) begin
         turn = TURN_NEG;
      end else begin
         turn = TURN_POS;
      end
   end

endmodule

`default_nettype wire

// ===== src/pip_edge_eval.sv =====
// Edge verdict: segment crossing from four turns plus box tests, and the
// collinear on-edge check. Depends on pip_pkg.
`default_nettype none

module pip_edge_eval (
   input  pip_pkg::pt_type      pt_a,
   input  pip_pkg::pt_type      pt_b,
   input  pip_pkg::pt_type      pt_p,
   input  pip_pkg::pt_type      pt_e,
   input  pip_pkg::turns_type   turns,
   output pip_pkg::verdict_type verdict
);
   import pip_pkg::*;

   function automatic logic in_box(input pt_type a, input pt_type q, input pt_type b);
      in_box = ($signed(q.x) <= $signed(a.x) || $signed(q.x) <= $signed(b.x)) &&
               ($signed(q.x) >= $signed(a.x) || $signed(q.x) >= $signed(b.x)) &&
               ($signed(q.y) <= $signed(a.y) || $signed(q.y) <= $signed(b.y)) &&
               ($signed(q.y) >= $signed(a.y) || $signed(q.y) >= $signed(b.y));
   endfunction

   logic general;

   assign general = (turns.o1 != turns.o2) && (turns.o3 != turns.o4);

   assign verdict.crossed = general ||
                            (turns.o1 == TURN_COLL && in_box(pt_a, pt_p, pt_b)) ||
                            (turns.o2 == TURN_COLL && in_box(pt_a, pt_e, pt_b)) ||
                            (turns.o3 == TURN_COLL && in_box(pt_p, pt_a, pt_e)) ||
                            (turns.o4 == TURN_COLL && in_box(pt_p, pt_b, pt_e));
   assign verdict.collinear = (turns.o5 == TURN_COLL);
   assign verdict.on_edge   = in_box(pt_a, pt_p, pt_b);

endmodule

`default_nettype wire

// ===== src/point_in_polygon_test.sv =====
// Point-in-polygon test top level: vertex store, sequencer, shared turn unit.
// Depends on pip_pkg, pip_turn_unit, pip_edge_eval.
//
//   channel  dir  payload          handshake
//   req_     in   pip_pkg::req_type  req_valid / req_ready
//   rsp_     out  pip_pkg::rsp_type  rsp_valid / rsp_ready
//
// Clear and append are done in S_IDLE as the request is accepted. A query over
// N >= 3 vertices first reads vertex 0; each edge then needs a load step, five passes
// through the single turn unit and a verdict step; a collinear hit ends early.
// Fewer than three vertices go straight to S_DONE. Reset is synchronous and
// empties the polygon. A result waits in the output register; a query that
// finishes while it is still pending holds until it is taken.
`default_nettype none

module point_in_polygon_test #(
   parameter int MAX_VERTICES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pip_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pip_pkg::rsp_type rsp_data
);
   import pip_pkg::*;

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_FIRST = 6'b000010,
      S_LOAD  = 6'b000100,
      S_TURN  = 6'b001000,
      S_EVAL  = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic signed [PT_BITS-1:0] ray_ff, ray_in;
   pt_type p_ff, p_in, e_ff, e_in, a_ff, a_in, b_ff, b_in, first_ff, first_in;
   logic [CW-1:0] edge_ff, edge_in;
   logic [2:0] step_ff, step_in;
   turns_type turns_ff, turns_in;
   logic hits_ff, hits_in;
   rsp_type res_ff, res_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] rd_x_ff, rd_y_ff;
   logic [AW-1:0] rd_addr;
   logic wr_en;

   logic accept;
   logic signed [PT_BITS-1:0] px_ext, py_ext;
   pt_type rd_pt;
   pt_type op_a, op_b, op_c;
   turn_type turn;
   verdict_type verdict;
   logic last_edge;
   logic [CW:0] next2;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign px_ext  = {{2{req_data.coord_x[COORD_BITS-1]}}, req_data.coord_x};
   assign py_ext  = {{2{req_data.coord_y[COORD_BITS-1]}}, req_data.coord_y};
   assign rd_pt.x = {{2{rd_x_ff[COORD_BITS-1]}}, rd_x_ff};
   assign rd_pt.y = {{2{rd_y_ff[COORD_BITS-1]}}, rd_y_ff};

   assign last_edge = (edge_ff == count_ff - CW'(1));
   assign next2     = {1'b0, edge_ff} + (CW + 1)'(2);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[count_ff[AW-1:0]] <= req_data.coord_x;
         mem_y[count_ff[AW-1:0]] <= req_data.coord_y;
      end
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
   end

   always_comb begin
      case (step_ff)
         3'd0: begin op_a = a_ff; op_b = b_ff; op_c = p_ff; end
         3'd1: begin op_a = a_ff; op_b = b_ff; op_c = e_ff; end
         3'd2: begin op_a = p_ff; op_b = e_ff; op_c = a_ff; end
         3'd3: begin op_a = p_ff; op_b = e_ff; op_c = b_ff; end
         default: begin op_a = a_ff; op_b = p_ff; op_c = b_ff; end
      endcase
   end

   pip_turn_unit u_turn (
      .pt_a (op_a),
      .pt_b (op_b),
      .pt_c (op_c),
      .turn (turn)
   );

   pip_edge_eval u_eval (
      .pt_a    (a_ff),
      .pt_b    (b_ff),
      .pt_p    (p_ff),
      .pt_e    (e_ff),
      .turns   (turns_ff),
      .verdict (verdict)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ray_in       = ray_ff;
      p_in         = p_ff;
      e_in         = e_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      first_in     = first_ff;
      edge_in      = edge_ff;
      step_in      = step_ff;
      turns_in     = turns_ff;
      hits_in      = hits_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_addr      = '0;
      wr_en        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.op)
                  OP_CLEAR: begin
                     count_in = '0;
                     ray_in   = '0;
                  end
                  OP_APPEND: begin
                     if (count_ff < CW'(MAX_VERTICES)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                        if (px_ext > ray_ff) begin
                           ray_in = px_ext + PT_BITS'(RAY_MARGIN);
                        end
                     end
                  end
                  OP_QUERY: begin
                     p_in.x  = px_ext;
                     p_in.y  = py_ext;
                     e_in.x  = (px_ext > ray_ff) ? px_ext + PT_BITS'(RAY_MARGIN) : ray_ff;
                     e_in.y  = py_ext;
                     hits_in = 1'b0;
                     if (count_ff < CW'(MIN_VERTICES)) begin
                        res_in   = '{inside_res: 1'b0, decided_on_edge: 1'b0,
                                     too_few_vertices: 1'b1};
                        state_in = S_DONE;
                     end else begin
                        state_in = S_FIRST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FIRST: begin
            a_in     = rd_pt;
            first_in = rd_pt;
            edge_in  = '0;
            rd_addr  = AW'(1);
            state_in = S_LOAD;
         end
         S_LOAD: begin
            b_in     = last_edge ? first_ff : rd_pt;
            step_in  = '0;
            state_in = S_TURN;
         end
         S_TURN: begin
            case (step_ff)
               3'd0: turns_in.o1 = turn;
               3'd1: turns_in.o2 = turn;
               3'd2: turns_in.o3 = turn;
               3'd3: turns_in.o4 = turn;
               default: turns_in.o5 = turn;
            endcase
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd4) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (verdict.crossed && verdict.collinear) begin
               res_in   = '{inside_res: verdict.on_edge, decided_on_edge: 1'b1,
                            too_few_vertices: 1'b0};
               state_in = S_DONE;
            end else begin
               hits_in = hits_ff ^ verdict.crossed;
               if (last_edge) begin
                  res_in   = '{inside_res: hits_ff ^ verdict.crossed, decided_on_edge: 1'b0,
                               too_few_vertices: 1'b0};
                  state_in = S_DONE;
               end else begin
                  a_in     = b_ff;
                  edge_in  = edge_ff + CW'(1);
                  rd_addr  = (next2 < (CW + 1)'(MAX_VERTICES)) ? next2[AW-1:0] : '0;
                  state_in = S_LOAD;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ray_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ray_ff       <= ray_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff     <= p_in;
      e_ff     <= e_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      first_ff <= first_in;
      edge_ff  <= edge_in;
      step_ff  <= step_in;
      turns_ff <= turns_in;
      hits_ff  <= hits_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_VERTICES))
      else $error("vertex count above capacity");

   a_edge_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EVAL |-> edge_ff < count_ff)
      else $error("edge index beyond vertex count");

   a_short_query: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.op == OP_QUERY && count_ff < CW'(MIN_VERTICES) |=>
      state_ff == S_DONE && res_ff.too_few_vertices)
      else $error("short polygon query not flagged");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.decided_on_edge && rsp_ff.too_few_vertices))
      else $error("edge exit and short polygon flagged together");

endmodule

`default_nettype wire
